>>> hw/rtl/xenc_pkg.sv
// Shared types, codes and sizes of the x86-64 instruction encoder.
`default_nettype none

package xenc_pkg;

  // Default width of the byte-position counter.
  localparam int unsigned POS_BITS_DEF = 32;

  // Number of entries in the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Most bytes one instruction can take (REX, opcode, 64-bit immediate).
  localparam int unsigned MAX_BYTES = 10;

  typedef enum logic [4:0] {
    RT_MOVRR    = 5'd0,
    RT_MOVIMM64 = 5'd1,
    RT_ADD      = 5'd2,
    RT_SUB      = 5'd3,
    RT_CMP      = 5'd4,
    RT_LOAD     = 5'd5,
    RT_STORE    = 5'd6,
    RT_PUSH     = 5'd7,
    RT_POP      = 5'd8,
    RT_JMP      = 5'd9,
    RT_JZ       = 5'd10,
    RT_JNZ      = 5'd11,
    RT_CALL     = 5'd12,
    RT_RET      = 5'd13,
    RT_NOP      = 5'd14,
    RT_INT3     = 5'd15,
    RT_JMP_LBL  = 5'd16,
    RT_JZ_LBL   = 5'd17,
    RT_JNZ_LBL  = 5'd18
  } req_type_e;

  // One classified instruction: its fixed bytes, byte count and, for jumps
  // to a bound target, where the rel32 field starts and target minus length.
  typedef struct packed {
    logic [8*MAX_BYTES-1:0] bytes;
    logic [3:0]             cnt;
    logic                   label;
    logic [1:0]             rel_off;
    logic [31:0]            tgt_adj;
  } desc_t;

endpackage

`default_nettype wire

>>> hw/rtl/xenc_front.sv
// Front part: classify one request into an instruction descriptor.
`default_nettype none

module xenc_front (
  input  wire logic [4:0]     req_type_i,
  input  wire logic [3:0]     dst_reg_i,
  input  wire logic [3:0]     src_reg_i,
  input  wire logic [3:0]     base_reg_i,
  input  wire logic [63:0]    immediate_i,
  input  wire logic [31:0]    displacement_i,
  input  wire logic [31:0]    target_pos_i,
  output xenc_pkg::desc_t     desc_o,
  output logic                known_o
);
  import xenc_pkg::*;

  logic [3:0]  mem_reg;
  logic [7:0]  mem_op;
  logic [1:0]  mem_mod;
  logic        mem_sib;
  logic        fits8;
  logic [31:0] disp_bytes;
  logic [2:0]  disp_n;
  logic [39:0] tail;
  logic [2:0]  tail_n;
  logic [7:0]  modrm;
  logic [7:0]  rr_op;

  // Memory operand: ModRM, optional SIB and displacement.
  always_comb begin
    mem_reg = (req_type_e'(req_type_i) == RT_LOAD) ? dst_reg_i : src_reg_i;
    mem_op  = (req_type_e'(req_type_i) == RT_LOAD) ? 8'h8B : 8'h89;
    fits8   = (displacement_i[31:7] == '0) || (displacement_i[31:7] == '1);
    if ((displacement_i == '0) && (base_reg_i[2:0] != 3'd5)) begin
      mem_mod = 2'd0;
    end else if (fits8) begin
      mem_mod = 2'd1;
    end else begin
      mem_mod = 2'd2;
    end
    mem_sib = (base_reg_i[2:0] == 3'd4);
    unique case (mem_mod)
      2'd1: begin
        disp_bytes = {24'h0, displacement_i[7:0]};
        disp_n     = 3'd1;
      end
      2'd2: begin
        disp_bytes = displacement_i;
        disp_n     = 3'd4;
      end
      default: begin
        disp_bytes = '0;
        disp_n     = 3'd0;
      end
    endcase
    if (mem_sib) begin
      tail   = {disp_bytes, 8'h24};
      tail_n = disp_n + 3'd1;
    end else begin
      tail   = {8'h00, disp_bytes};
      tail_n = disp_n;
    end
    modrm = {mem_mod, mem_reg[2:0], base_reg_i[2:0]};
  end

  always_comb begin
    desc_o  = '0;
    known_o = 1'b1;
    rr_op   = 8'h89;
    unique case (req_type_e'(req_type_i))
      RT_MOVRR, RT_ADD, RT_SUB, RT_CMP: begin
        unique case (req_type_e'(req_type_i))
          RT_ADD:  rr_op = 8'h01;
          RT_SUB:  rr_op = 8'h29;
          RT_CMP:  rr_op = 8'h39;
          default: rr_op = 8'h89;
        endcase
        desc_o.bytes[23:0] = {2'b11, src_reg_i[2:0], dst_reg_i[2:0], rr_op,
                              5'b01001, src_reg_i[3], 1'b0, dst_reg_i[3]};
        desc_o.cnt = 4'd3;
      end
      RT_MOVIMM64: begin
        desc_o.bytes = {immediate_i, 5'b10111, dst_reg_i[2:0],
                        7'b0100100, dst_reg_i[3]};
        desc_o.cnt = 4'd10;
      end
      RT_LOAD, RT_STORE: begin
        desc_o.bytes[63:0] = {tail, modrm, mem_op,
                              5'b01001, mem_reg[3], 1'b0, base_reg_i[3]};
        desc_o.cnt = 4'd3 + {1'b0, tail_n};
      end
      RT_PUSH, RT_POP: begin
        if (dst_reg_i[3]) begin
          desc_o.bytes[15:0] = {4'h5, (req_type_e'(req_type_i) == RT_POP),
                                dst_reg_i[2:0], 8'h41};
          desc_o.cnt = 4'd2;
        end else begin
          desc_o.bytes[7:0] = {4'h5, (req_type_e'(req_type_i) == RT_POP),
                               dst_reg_i[2:0]};
          desc_o.cnt = 4'd1;
        end
      end
      RT_JMP, RT_CALL: begin
        desc_o.bytes[39:0] = {displacement_i,
                              (req_type_e'(req_type_i) == RT_JMP) ? 8'hE9 : 8'hE8};
        desc_o.cnt = 4'd5;
      end
      RT_JZ, RT_JNZ: begin
        desc_o.bytes[47:0] = {displacement_i,
                              (req_type_e'(req_type_i) == RT_JZ) ? 8'h84 : 8'h85,
                              8'h0F};
        desc_o.cnt = 4'd6;
      end
      RT_RET: begin
        desc_o.bytes[7:0] = 8'hC3;
        desc_o.cnt = 4'd1;
      end
      RT_NOP: begin
        desc_o.bytes[7:0] = 8'h90;
        desc_o.cnt = 4'd1;
      end
      RT_INT3: begin
        desc_o.bytes[7:0] = 8'hCC;
        desc_o.cnt = 4'd1;
      end
      RT_JMP_LBL: begin
        desc_o.bytes[7:0] = 8'hE9;
        desc_o.cnt     = 4'd5;
        desc_o.label   = 1'b1;
        desc_o.rel_off = 2'd1;
        desc_o.tgt_adj = target_pos_i - 32'd5;
      end
      RT_JZ_LBL, RT_JNZ_LBL: begin
        desc_o.bytes[15:0] = {(req_type_e'(req_type_i) == RT_JZ_LBL) ? 8'h84 : 8'h85,
                              8'h0F};
        desc_o.cnt     = 4'd6;
        desc_o.label   = 1'b1;
        desc_o.rel_off = 2'd2;
        desc_o.tgt_adj = target_pos_i - 32'd6;
      end
      default: begin
        known_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/xenc_queue.sv
// Short descriptor queue between the front and the back.
`default_nettype none

module xenc_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire xenc_pkg::desc_t wdata_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output xenc_pkg::desc_t      rdata_o
);
  import xenc_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  desc_t           mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/xenc_back.sv
// Back part: send the queued instruction with its position, one byte per cycle while code_stall_i is low.
`default_nettype none

module xenc_back #(
  parameter int unsigned POS_BITS = xenc_pkg::POS_BITS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_valid_i,
  input  wire xenc_pkg::desc_t q_desc_i,
  output logic                 q_pop_o,
  output logic                 code_valid_o,
  input  wire logic            code_stall_i,
  output logic [7:0]           code_byte_o,
  output logic                 last_byte_o,
  output logic [31:0]          byte_pos_o
);
  import xenc_pkg::*;

  logic [POS_BITS-1:0] write_pos_q, write_pos_d;
  logic [31:0]         pos32;
  logic [3:0]          idx_q, idx_d;
  logic                out_valid_q, out_valid_d;
  logic [7:0]          byte_q;
  logic                last_q;
  logic [31:0]         pos_q;
  logic                advance;
  logic                emit;
  logic                is_last;
  logic [31:0]         rel;
  logic [1:0]          rel_sel;
  logic [7:0]          cur_byte;

  if (POS_BITS >= 32) begin : g_pos_wide
    assign pos32 = write_pos_q[31:0];
  end else begin : g_pos_narrow
    assign pos32 = {{(32 - POS_BITS){1'b0}}, write_pos_q};
  end

  assign advance = !out_valid_q || !code_stall_i;
  assign emit    = advance && q_valid_i;
  assign is_last = (idx_q == q_desc_i.cnt - 4'd1);
  assign q_pop_o = emit && is_last;

  // rel32 of a label jump: target minus the position after the jump.
  always_comb begin
    rel     = q_desc_i.tgt_adj + {28'h0, idx_q} - pos32;
    rel_sel = 2'(idx_q - {2'b00, q_desc_i.rel_off});
    if (q_desc_i.label && (idx_q >= {2'b00, q_desc_i.rel_off})) begin
      cur_byte = rel[{rel_sel, 3'b000} +: 8];
    end else begin
      cur_byte = q_desc_i.bytes[{idx_q, 3'b000} +: 8];
    end
  end

  always_comb begin
    write_pos_d = write_pos_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      write_pos_d = write_pos_q + POS_BITS'(1);
      idx_d       = is_last ? 4'd0 : idx_q + 4'd1;
      out_valid_d = 1'b1;
    end else if (advance) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_pos_q <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      write_pos_q <= write_pos_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q <= cur_byte;
      last_q <= is_last;
      pos_q  <= pos32;
    end
  end

  assign code_valid_o = out_valid_q;
  assign code_byte_o  = byte_q;
  assign last_byte_o  = last_q;
  assign byte_pos_o   = pos_q;

endmodule

`default_nettype wire

>>> hw/rtl/x86_64_instruction_encoder_top.sv
// Top level of the x86-64 instruction encoder: front, queue and back.
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+-------------------------------------
//  req     | in        | req_valid_i / req_stall_o  | type, registers, immediate, disp, target
//  code    | out       | code_valid_o / code_stall_i| code_byte, last_byte, byte_pos
//
// Bytes leave one per cycle while code_stall_i is low; an instruction has 1 to
// 10 bytes, with 10 for a 64-bit immediate move. The output byte port of the
// back part sets that rate. Reset empties the queue and clears the byte
// position. A request is taken whenever the queue has room, even while the
// back is stalled; the output register holds its byte until code_stall_i drops.
`default_nettype none

module x86_64_instruction_encoder_top #(
  parameter int unsigned POS_BITS = xenc_pkg::POS_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        req_valid_i,
  output logic             req_stall_o,
  input  wire logic [4:0]  req_type_i,
  input  wire logic [3:0]  dst_reg_i,
  input  wire logic [3:0]  src_reg_i,
  input  wire logic [3:0]  base_reg_i,
  input  wire logic [63:0] immediate_i,
  input  wire logic [31:0] displacement_i,
  input  wire logic [31:0] target_pos_i,
  // code byte channel
  output logic             code_valid_o,
  input  wire logic        code_stall_i,
  output logic [7:0]       code_byte_o,
  output logic             last_byte_o,
  output logic [31:0]      byte_pos_o
);
  import xenc_pkg::*;

  desc_t front_desc;
  logic  front_known;
  logic  q_full;
  logic  q_push;
  logic  q_pop;
  logic  q_valid;
  desc_t q_desc;

  // Classify the request into its fixed bytes and length.
  xenc_front u_front (
    .req_type_i     (req_type_i),
    .dst_reg_i      (dst_reg_i),
    .src_reg_i      (src_reg_i),
    .base_reg_i     (base_reg_i),
    .immediate_i    (immediate_i),
    .displacement_i (displacement_i),
    .target_pos_i   (target_pos_i),
    .desc_o         (front_desc),
    .known_o        (front_known)
  );

  // Hold off requests only when the queue is full; drop unknown types.
  assign req_stall_o = q_full;
  assign q_push      = req_valid_i && !q_full && front_known;

  xenc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (front_desc),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_desc)
  );

  // Advance through the head instruction, one byte per free output slot.
  xenc_back #(
    .POS_BITS (POS_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_desc_i     (q_desc),
    .q_pop_o      (q_pop),
    .code_valid_o (code_valid_o),
    .code_stall_i (code_stall_i),
    .code_byte_o  (code_byte_o),
    .last_byte_o  (last_byte_o),
    .byte_pos_o   (byte_pos_o)
  );

endmodule

`default_nettype wire
